FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or same-cycle implication, checked at every clock edge.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent in one cycle, consequent in a later one.
`define ASSERT_AFTER2(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

FILE: rtl/bcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_pkg
// Types and constants of the bounded circular deque.
// ---------------------------------------------------------------------------
package bcd_pkg;

    localparam int CFG_W    = 11;
    localparam int FUNC_W   = 3;
    localparam int RESULT_W = 32;
    localparam int OUT_W    = 40;

    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_REAR  = 3'd5
    } func_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // accepted beat that completes this cycle
        logic rd_issue;  // accepted peek that needs a store read
        logic rd_load;   // store read data is back, load result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic peek_hit;  // pending beat is a peek on a non-empty deque
        logic out_valid;
    } stat_t;

endpackage

FILE: rtl/bcd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bcd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_ctrl
// Controller: beat acceptance and the read state of a store read.
// ---------------------------------------------------------------------------
module bcd_ctrl
    import bcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !stat.out_valid || m_tready;
    assign accept    = (state_reg == ST_IDLE) && slot_free && s_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.peek_hit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.rd_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = slot_free;
                cmd.exec     = accept && !stat.peek_hit;
                cmd.rd_issue = accept && stat.peek_hit;
            end
            ST_READ:
            begin
                // output slot was freed when the peek was accepted
                cmd.rd_load = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/bcd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_datapath
// Head pointer, entry count, capacity, ring store and result register.
// ---------------------------------------------------------------------------
module bcd_datapath
    import bcd_pkg::*;
#(
    parameter int MAX_DEPTH  = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [FUNC_W-1:0]   func,
    input  logic [RESULT_W-1:0] push_value,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [OUT_W-1:0]    m_tdata
);

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0)
        begin
            w = 32'd1;
        end
        if (w > 32'(MAX_DEPTH))
        begin
            w = 32'(MAX_DEPTH);
        end
        return CNT_W'(w);
    endfunction

    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    cap_reg;

    logic                out_valid_reg;
    logic                ok_reg;
    logic [RESULT_W-1:0] rd_reg;
    logic                empty_reg;
    logic                full_reg;

    logic                empty;
    logic                full;
    logic [SUM_W-1:0]    head_w;
    logic [SUM_W-1:0]    cap_w;
    logic [SUM_W-1:0]    rear_raw;
    logic [SUM_W-1:0]    rear_idx;
    logic [SUM_W-1:0]    last_raw;
    logic [SUM_W-1:0]    last_idx;
    logic [SUM_W-1:0]    next_front;
    logic [SUM_W-1:0]    prev_front;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic                ok_c;
    logic [RESULT_W-1:0] rd_c;
    logic                is_peek;

    logic [DATA_WIDTH+RESULT_W-1:0] push_ext;
    logic [DATA_WIDTH+RESULT_W-1:0] read_ext;
    logic [DATA_WIDTH-1:0]          ram_rdata;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg >= cap_reg);
    assign head_w = SUM_W'(head_reg);
    assign cap_w  = SUM_W'(cap_reg);

    // ring offsets: sums stay below twice the capacity, one subtract wraps
    assign rear_raw   = head_w + SUM_W'(count_reg);
    assign rear_idx   = (rear_raw >= cap_w) ? rear_raw - cap_w : rear_raw;
    assign last_raw   = head_w + SUM_W'(count_reg) - SUM_W'(1);
    assign last_idx   = (last_raw >= cap_w) ? last_raw - cap_w : last_raw;
    assign next_front = ((head_w + SUM_W'(1)) >= cap_w) ? '0 : head_w + SUM_W'(1);
    assign prev_front = (head_reg == '0) ? cap_w - SUM_W'(1) : head_w - SUM_W'(1);

    assign is_peek = (func == FN_PEEK_FRONT) || (func == FN_PEEK_REAR);

    assign stat.peek_hit  = is_peek && !empty;
    assign stat.out_valid = out_valid_reg;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = rear_idx[IDX_W-1:0];
        rd_addr    = head_reg;
        ok_c       = 1'b0;
        rd_c       = '0;
        case (func)
            FN_PUSH_FRONT:
            begin
                if (!full)
                begin
                    head_next  = prev_front[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    wr_en      = 1'b1;
                    wr_addr    = prev_front[IDX_W-1:0];
                    ok_c       = 1'b1;
                end
            end
            FN_PUSH_REAR:
            begin
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                    wr_en      = 1'b1;
                    ok_c       = 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (!empty)
                begin
                    head_next  = next_front[IDX_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                    ok_c       = 1'b1;
                end
            end
            FN_POP_REAR:
            begin
                if (!empty)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_c       = 1'b1;
                end
            end
            FN_PEEK_FRONT:
            begin
                // refused peek answers all ones
                if (empty)
                begin
                    rd_c = '1;
                end
            end
            FN_PEEK_REAR:
            begin
                rd_addr = last_idx[IDX_W-1:0];
                if (empty)
                begin
                    rd_c = '1;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign push_ext = {{DATA_WIDTH{1'b0}}, push_value};
    assign read_ext = {{RESULT_W{1'b0}}, ram_rdata};

    bcd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.exec && wr_en),
        .waddr (wr_addr),
        .wdata (push_ext[DATA_WIDTH-1:0]),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= eff_cap(CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg   <= eff_cap(cfg_wdata);
                head_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end

            if (cmd.exec || cmd.rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg    <= ok_c;
            rd_reg    <= rd_c;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next >= cap_reg);
        end
        else if (cmd.rd_load)
        begin
            ok_reg    <= 1'b1;
            rd_reg    <= read_ext[RESULT_W-1:0];
            empty_reg <= empty;
            full_reg  <= full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, full_reg, empty_reg, rd_reg, ok_reg};

endmodule

FILE: rtl/bounded_circular_deque.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_circular_deque
// Double-ended queue of words in a ring store, head pointer plus count.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: func; tdata: push_value
//  m_axis   | out       | tdata: ok, read_value, is_empty, is_full
//  cfg      | in        | queue_capacity write, empties the deque
//
//  Push, pop, unknown codes and peeks on an empty deque complete on acceptance;
//  a non-empty peek holds s_tready low in ST_READ for the registered store read.
//  A new beat is taken while the result register drains on the same edge.
//  Reset clears head, count and capacity (1024, clipped to MAX_DEPTH);
//  the store holds no reset state and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_circular_deque
    import bcd_pkg::*;
#(
    parameter int MAX_DEPTH  = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [RESULT_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [FUNC_W-1:0]   s_tuser,   // [2:0] func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [0] ok, [32:1] read_value,
                                           // [33] is_empty, [34] is_full
);

    cmd_t  cmd;
    stat_t stat;

    bcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcd_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .func       (s_tuser),
        .push_value (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    `ASSERT_HOLDS(a_no_accept_on_stall, clk, rst_n, !(m_tvalid && !m_tready) || !s_tready, "beat accepted while result stalled")
    `ASSERT_NEXT(a_exec_result, clk, rst_n, cmd.exec, m_tvalid && !s_tready == !m_tready, "completed beat not presented next cycle")
    `ASSERT_AFTER2(a_peek_result, clk, rst_n, cmd.rd_issue, m_tvalid && m_tdata[0], "peek result missing two cycles after issue")
    `ASSERT_HOLDS(a_empty_not_full, clk, rst_n, !m_tvalid || !(m_tdata[33] && m_tdata[34]), "result reports empty and full together")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks bounded_circular_deque. Every operation beat is mirrored in a
// behavioral deque (head pointer plus count over a ring of words). Each
// result beat is compared field by field with the oldest predicted result.
// The run covers several capacity settings, from the clipped low end to a
// full 1024-entry ring, with random gaps on both streams and long output
// stalls.
// ---------------------------------------------------------------------------
module testbench;
    import bcd_pkg::*;

    localparam int                 DEPTH        = 1024;
    localparam logic [FUNC_W-1:0]  FN_SPARE_6   = 3'd6;
    localparam logic [FUNC_W-1:0]  FN_SPARE_7   = 3'd7;
    localparam logic [31:0]        REFUSED_PEEK = 32'hFFFF_FFFF;
    localparam int                 HOLD_CYCLES  = 150;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [31:0]       push_value;
    } deque_op_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic        is_empty;
        logic        is_full;
    } deque_result_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [RESULT_W-1:0] s_tdata   = '0;   // [31:0] push_value
    logic [FUNC_W-1:0]   s_tuser   = '0;   // [2:0] func
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;          // [0] ok, [32:1] read_value,
                                           // [33] is_empty, [34] is_full

    // behavioral deque
    logic [31:0]  shadow_store [DEPTH];
    int unsigned  shadow_head;
    int unsigned  shadow_count;
    logic [CFG_W-1:0] shadow_cap_reg = CAP_RESET;

    deque_op_t     pending_ops[$];
    deque_result_t predicted_results[$];
    int            ops_issued   = 0;
    int            ops_accepted = 0;
    int            results_seen = 0;
    int            fail_count   = 0;

    int        src_gap      = 0;
    int        src_max_gap  = 9;
    int        sink_max_gap = 9;
    int        sink_wait    = 0;
    int        sink_beats   = 0;
    deque_op_t next_op;
    deque_op_t seen_op;
    deque_result_t want;

    bounded_circular_deque u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned live_capacity();
        int unsigned c;
        c = 32'(shadow_cap_reg);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned ring_index(int unsigned base, int unsigned off,
                                               int unsigned cap);
        int unsigned s;
        s = base + off;
        if (s >= cap)
            s = s - cap;
        return s;
    endfunction

    function automatic deque_result_t apply_deque_op(deque_op_t op);
        int unsigned   cap;
        int unsigned   slot;
        deque_result_t r;
        cap = live_capacity();
        r   = '0;
        case (op.func)
            FN_PUSH_FRONT:
                if (shadow_count < cap)
                begin
                    shadow_head = (shadow_head == 0) ? cap - 1 : shadow_head - 1;
                    shadow_store[shadow_head] = op.push_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            FN_PUSH_REAR:
                if (shadow_count < cap)
                begin
                    slot = ring_index(shadow_head, shadow_count, cap);
                    shadow_store[slot] = op.push_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            FN_POP_FRONT:
                if (shadow_count != 0)
                begin
                    shadow_head = ring_index(shadow_head, 1, cap);
                    shadow_count--;
                    r.ok = 1'b1;
                end
            FN_POP_REAR:
                if (shadow_count != 0)
                begin
                    shadow_count--;
                    r.ok = 1'b1;
                end
            FN_PEEK_FRONT, FN_PEEK_REAR:
                if (shadow_count == 0)
                    r.read_value = REFUSED_PEEK;
                else
                begin
                    slot = (op.func == FN_PEEK_FRONT) ? shadow_head
                         : ring_index(shadow_head, shadow_count - 1, cap);
                    r.read_value = shadow_store[slot];
                    r.ok = 1'b1;
                end
            default: ;
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full  = (shadow_count >= cap);
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %h, got %h", field, want_v, got_v);
            fail_count++;
        end
    endtask

    // driver: next beat goes out once the current one is taken and its gap ran out
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (src_gap > 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                next_op   = pending_ops.pop_front();
                s_tdata  <= next_op.push_value;
                s_tuser  <= next_op.func;
                s_tvalid <= 1'b1;
                src_gap  <= $urandom_range(0, src_max_gap);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random wait after each beat, plus a long hold now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sink_beats++;
                if (sink_beats % 400 == 200)
                    sink_wait = HOLD_CYCLES;
                else
                    sink_wait = $urandom_range(0, sink_max_gap);
            end
            else if (sink_wait > 0)
                sink_wait--;
            m_tready <= (sink_wait == 0);
        end
    end

    // monitor: results are checked before this edge's op is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with no operation outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("ok", 32'(want.ok), 32'(m_tdata[0]));
                    check_field("read_value", want.read_value, m_tdata[32:1]);
                    check_field("is_empty", 32'(want.is_empty), 32'(m_tdata[33]));
                    check_field("is_full", 32'(want.is_full), 32'(m_tdata[34]));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                seen_op.func       = s_tuser;
                seen_op.push_value = s_tdata;
                predicted_results.insert(predicted_results.size(),
                                         apply_deque_op(seen_op));
                ops_accepted++;
            end
        end
    end

    task automatic queue_op(logic [FUNC_W-1:0] func, logic [31:0] value);
        deque_op_t op;
        op.func       = func;
        op.push_value = value;
        pending_ops.insert(pending_ops.size(), op);
        ops_issued++;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // push_pct / pop_pct steer the fill level; the rest are peeks and spare codes
    task automatic queue_random_ops(int n, int push_pct, int pop_pct);
        int r;
        logic [FUNC_W-1:0] f;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                f = $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
            else if (r < push_pct + pop_pct)
                f = $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
            else if (r < 96)
                f = $urandom_range(0, 1) ? FN_PEEK_REAR : FN_PEEK_FRONT;
            else
                f = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
            queue_op(f, random_word());
        end
    endtask

    // all beats taken and answered
    task automatic wait_idle();
        while (!(ops_accepted == ops_issued && results_seen == ops_accepted))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // a capacity write also empties the deque
        shadow_cap_reg = value;
        shadow_head    = 0;
        shadow_count   = 0;
    endtask

    initial
    begin
        shadow_head  = 0;
        shadow_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: empty refusals, spare codes, extremes at both ends
        queue_op(FN_PEEK_FRONT, 32'h1234_5678);
        queue_op(FN_PEEK_REAR,  32'h0);
        queue_op(FN_POP_FRONT,  32'h0);
        queue_op(FN_POP_REAR,   32'h0);
        queue_op(FN_SPARE_6,    32'hFFFF_FFFF);
        queue_op(FN_SPARE_7,    32'h0);
        queue_op(FN_PUSH_FRONT, 32'h7FFF_FFFF);   // head wraps below zero
        queue_op(FN_PUSH_REAR,  32'h8000_0000);
        queue_op(FN_PUSH_FRONT, 32'h0000_0000);
        queue_op(FN_PUSH_REAR,  32'hFFFF_FFFF);
        queue_op(FN_PEEK_FRONT, 32'h0);
        queue_op(FN_PEEK_REAR,  32'h0);
        queue_op(FN_SPARE_6,    32'hA5A5_A5A5);
        queue_op(FN_POP_FRONT,  32'h0);
        queue_op(FN_PEEK_FRONT, 32'h0);
        queue_op(FN_POP_REAR,   32'h0);
        queue_op(FN_PEEK_REAR,  32'h0);
        queue_op(FN_POP_REAR,   32'h0);
        queue_op(FN_POP_FRONT,  32'h0);
        queue_op(FN_POP_FRONT,  32'h0);
        queue_op(FN_PEEK_REAR,  32'h0);

        // zero capacity behaves as one entry
        write_capacity(11'd0);
        queue_op(FN_PUSH_REAR,  32'h5A5A_5A5A);
        queue_op(FN_PUSH_FRONT, 32'h1111_1111);
        queue_op(FN_PEEK_REAR,  32'h0);
        queue_op(FN_POP_FRONT,  32'h0);
        queue_op(FN_PUSH_FRONT, 32'hA5A5_A5A5);
        queue_op(FN_PEEK_FRONT, 32'h0);
        queue_random_ops(60, 35, 30);

        src_max_gap  = 0;
        sink_max_gap = 0;
        write_capacity(11'd1);
        queue_random_ops(50, 35, 30);

        src_max_gap  = 9;
        sink_max_gap = 9;
        write_capacity(11'd2);
        queue_random_ops(60, 35, 30);

        // above the ring size: clipped to 1024
        src_max_gap  = 0;
        write_capacity(11'd2047);
        queue_random_ops(30, 40, 25);

        // fill the full ring past the top, then drain part of it
        src_max_gap  = 3;
        sink_max_gap = 3;
        write_capacity(11'd1024);
        for (int i = 0; i < DEPTH + 4; i++)
        begin
            queue_op($urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT, random_word());
            if (i % 128 == 0)
                queue_op($urandom_range(0, 1) ? FN_PEEK_REAR : FN_PEEK_FRONT, random_word());
        end
        queue_random_ops(20, 10, 60);

        src_max_gap  = 9;
        sink_max_gap = 0;
        write_capacity(11'd7);
        queue_random_ops(80, 38, 30);

        src_max_gap  = 9;
        sink_max_gap = 9;
        write_capacity(11'd13);
        queue_random_ops(60, 38, 30);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
